>>> design/jms_pkg.sv
// shared types, class codes and the marker classifier for the jpeg marker segmenter
package jms_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [4:0] CL_SOI     = 5'd0;
  localparam logic [4:0] CL_EOI     = 5'd1;
  localparam logic [4:0] CL_RST     = 5'd2;
  localparam logic [4:0] CL_DHT     = 5'd3;
  localparam logic [4:0] CL_SPECIAL = 5'd4;
  localparam logic [4:0] CL_SOF     = 5'd5;
  localparam logic [4:0] CL_SOS     = 5'd6;
  localparam logic [4:0] CL_DQT     = 5'd7;
  localparam logic [4:0] CL_DNL     = 5'd8;
  localparam logic [4:0] CL_DRI     = 5'd9;
  localparam logic [4:0] CL_APP0    = 5'd10;
  localparam logic [4:0] CL_APP1    = 5'd11;
  localparam logic [4:0] CL_APP2    = 5'd12;
  localparam logic [4:0] CL_APPN    = 5'd13;
  localparam logic [4:0] CL_COM     = 5'd14;
  localparam logic [4:0] CL_RES     = 5'd15;
  localparam logic [4:0] CL_UNKNOWN = 5'd16;
  localparam logic [4:0] CL_DATA    = 5'd17;
  localparam logic [4:0] CL_NONE    = 5'd18;

  typedef struct packed {
    logic [7:0] data;
    logic       stream_end;
    logic [4:0] code_class;
    logic       is_ff;
    logic       is_zero;
  } item_t;

  typedef struct packed {
    logic [7:0]  byte_echo;
    logic [4:0]  seg_class;
    logic        first_of_segment;
    logic        last_of_segment;
    logic        image_data_end;
    logic        stuffed_zero;
    logic [16:0] seg_total_length;
    logic [2:0]  status;
  } result_t;

  function automatic logic [4:0] classify(input logic [7:0] c);
    logic [4:0] r;
    priority if (c == 8'hd8) r = CL_SOI;
    else if (c == 8'hd9) r = CL_EOI;
    else if (c >= 8'hd0 && c <= 8'hd7) r = CL_RST;
    else if (c == 8'hc4) r = CL_DHT;
    else if (c == 8'hcc) r = CL_SPECIAL;
    else if (c >= 8'hc0 && c <= 8'hcf) r = CL_SOF;
    else if (c == 8'hda) r = CL_SOS;
    else if (c == 8'hdb) r = CL_DQT;
    else if (c == 8'hdc) r = CL_DNL;
    else if (c == 8'hdd) r = CL_DRI;
    else if (c == 8'hde || c == 8'hdf) r = CL_SPECIAL;
    else if (c == 8'he0) r = CL_APP0;
    else if (c == 8'he1) r = CL_APP1;
    else if (c == 8'he2) r = CL_APP2;
    else if (c >= 8'he3 && c <= 8'hef) r = CL_APPN;
    else if (c == 8'hfe) r = CL_COM;
    else if (c == 8'h01) r = CL_SPECIAL;
    else if ((c >= 8'h03 && c <= 8'hbf) || (c >= 8'hf0 && c <= 8'hfd)) r = CL_RES;
    else r = CL_UNKNOWN;
    return r;
  endfunction

endpackage

>>> design/jpeg_marker_segmenter.sv
// jpeg marker segmenter top level: classifier, queue and segment parser
// a byte is written into a queue slot and then into the registered result before it leaves
// throughput: one byte per cycle while the output is not stalled by m_axis_tready
// the four-entry queue takes bytes while the output register is stalled
// synchronous active-high reset returns the parser to expecting the opening ff d8
// and empties the queue and output register
module jpeg_marker_segmenter import jms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // byte_echo, first_of_segment, image_data_end,
                                      // seg_total_length, status, zero fill
  output logic [5:0]  m_axis_tuser,   // seg_class, stuffed_zero
  output logic        m_axis_tlast
);

  item_t   front_item;
  item_t   q_item;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  assign s_axis_tready = !q_full;

  jms_front u_front (
    .data       (s_axis_tdata),
    .stream_end (s_axis_tlast),
    .item       (front_item)
  );

  jms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (s_axis_tvalid && !q_full),
    .wr_item  (front_item),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  jms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {2'b00, res.status, res.seg_total_length, res.image_data_end,
                         res.first_of_segment, res.byte_echo};
  assign m_axis_tuser = {res.stuffed_zero, res.seg_class};
  assign m_axis_tlast = res.last_of_segment;

endmodule

>>> design/jms_front.sv
// front end: classifies each incoming byte before it enters the queue
module jms_front import jms_pkg::*; (
  input  logic [7:0] data,
  input  logic       stream_end,
  output item_t      item
);

  always_comb begin
    item.data       = data;
    item.stream_end = stream_end;
    item.code_class = classify(data);
    item.is_ff      = (data == 8'hff);
    item.is_zero    = (data == 8'h00);
  end

endmodule

>>> design/jms_queue.sv
// short queue of classified bytes between front and back
module jms_queue import jms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output logic  rd_valid,
  output item_t rd_item
);

  item_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> count != '0)
    else $error("pop from empty queue");

endmodule

>>> design/jms_back.sv
// back end: marker segment parser with registered result
module jms_back import jms_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam logic [3:0] PH_SOI_FF    = 4'd0;
  localparam logic [3:0] PH_SOI_D8    = 4'd1;
  localparam logic [3:0] PH_MARK_FF   = 4'd2;
  localparam logic [3:0] PH_MARK_CODE = 4'd3;
  localparam logic [3:0] PH_LEN_HI    = 4'd4;
  localparam logic [3:0] PH_LEN_LO    = 4'd5;
  localparam logic [3:0] PH_PAYLOAD   = 4'd6;
  localparam logic [3:0] PH_SCAN_1ST  = 4'd7;
  localparam logic [3:0] PH_SCAN      = 4'd8;
  localparam logic [3:0] PH_DONE      = 4'd9;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_IGNORED   = 3'd1;
  localparam logic [2:0] ST_NO_SOI    = 3'd2;
  localparam logic [2:0] ST_NO_MARKER = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_STRAY     = 3'd6;

  logic [3:0]  phase, phase_next;
  logic [4:0]  current_class, current_class_next;
  logic [15:0] remaining_bytes, remaining_bytes_next;
  logic [7:0]  length_high, length_high_next;
  logic        scan_follows, scan_follows_next;
  logic        scan_saw_ff, scan_saw_ff_next;
  logic [16:0] seg_total, seg_total_next;

  logic [15:0] len_word;
  logic [16:0] len_total;
  logic [15:0] rem_dec;
  result_t     r;

  assign q_pop     = q_valid && (!res_valid || res_ready);
  assign len_word  = {length_high, q_item.data};
  assign len_total = {1'b0, len_word} + 17'd2;
  assign rem_dec   = remaining_bytes - 16'd1;

  always_comb begin
    r.byte_echo        = q_item.data;
    r.seg_class        = CL_NONE;
    r.first_of_segment = 1'b0;
    r.last_of_segment  = 1'b0;
    r.image_data_end   = 1'b0;
    r.stuffed_zero     = 1'b0;
    r.seg_total_length = '0;
    r.status           = ST_OK;
    phase_next           = phase;
    current_class_next   = current_class;
    remaining_bytes_next = remaining_bytes;
    length_high_next     = length_high;
    scan_follows_next    = scan_follows;
    scan_saw_ff_next     = scan_saw_ff;
    seg_total_next       = seg_total;
    unique case (phase)
      PH_SOI_FF: begin
        if (q_item.is_ff) begin
          r.seg_class        = CL_SOI;
          r.first_of_segment = 1'b1;
          phase_next         = PH_SOI_D8;
        end else begin
          r.status   = ST_NO_SOI;
          phase_next = PH_DONE;
        end
      end
      PH_SOI_D8: begin
        if (q_item.code_class == CL_SOI) begin
          r.seg_class        = CL_SOI;
          r.last_of_segment  = 1'b1;
          r.seg_total_length = 17'd2;
          phase_next         = PH_MARK_FF;
        end else begin
          r.status   = ST_NO_SOI;
          phase_next = PH_DONE;
        end
      end
      PH_MARK_FF: begin
        seg_total_next     = '0;
        current_class_next = CL_NONE;
        if (q_item.is_ff) begin
          r.first_of_segment = 1'b1;
          phase_next         = PH_MARK_CODE;
        end else begin
          r.status   = ST_NO_MARKER;
          phase_next = PH_DONE;
        end
      end
      PH_MARK_CODE: begin
        r.seg_class        = q_item.code_class;
        current_class_next = q_item.code_class;
        if (q_item.code_class <= CL_RST) begin
          r.last_of_segment  = 1'b1;
          r.seg_total_length = 17'd2;
          phase_next = (q_item.code_class == CL_EOI) ? PH_DONE : PH_MARK_FF;
        end else begin
          scan_follows_next = (q_item.code_class == CL_SOS);
          phase_next        = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        r.seg_class      = current_class;
        length_high_next = q_item.data;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        r.seg_class        = current_class;
        r.seg_total_length = len_total;
        seg_total_next     = len_total;
        if (len_word < 16'd2) begin
          r.status          = ST_BAD_LEN;
          r.last_of_segment = 1'b1;
          scan_follows_next = 1'b0;
          phase_next        = PH_DONE;
        end else if (len_word == 16'd2) begin
          r.last_of_segment = 1'b1;
          scan_follows_next = 1'b0;
          phase_next        = scan_follows ? PH_SCAN_1ST : PH_MARK_FF;
        end else begin
          remaining_bytes_next = len_word - 16'd2;
          phase_next           = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.seg_class          = current_class;
        r.seg_total_length   = seg_total;
        remaining_bytes_next = rem_dec;
        if (rem_dec == '0) begin
          r.last_of_segment = 1'b1;
          scan_follows_next = 1'b0;
          phase_next        = scan_follows ? PH_SCAN_1ST : PH_MARK_FF;
        end
      end
      PH_SCAN_1ST, PH_SCAN: begin
        if (phase == PH_SCAN_1ST) begin
          r.first_of_segment = 1'b1;
          seg_total_next     = '0;
        end
        current_class_next = CL_DATA;
        r.seg_class        = CL_DATA;
        phase_next         = PH_SCAN;
        if (!scan_saw_ff) begin
          if (q_item.is_ff) begin
            scan_saw_ff_next = 1'b1;
          end
        end else begin
          scan_saw_ff_next = 1'b0;
          priority if (q_item.is_zero) begin
            r.stuffed_zero = 1'b1;
          end else if (q_item.code_class == CL_EOI) begin
            r.seg_class        = CL_EOI;
            r.first_of_segment = 1'b0;
            r.last_of_segment  = 1'b1;
            r.image_data_end   = 1'b1;
            r.seg_total_length = 17'd2;
            current_class_next = CL_EOI;
            phase_next         = PH_DONE;
          end else if (q_item.code_class == CL_RST) begin
            r.status = ST_OK;
          end else begin
            r.status = ST_STRAY;
          end
        end
      end
      default: begin
        r.status   = ST_IGNORED;
        phase_next = PH_DONE;
      end
    endcase
    if (q_item.stream_end && phase_next != PH_DONE) begin
      r.status   = ST_TRUNC;
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SOI_FF;
      current_class   <= CL_NONE;
      remaining_bytes <= '0;
      length_high     <= '0;
      scan_follows    <= 1'b0;
      scan_saw_ff     <= 1'b0;
      seg_total       <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (q_pop) begin
        phase           <= phase_next;
        current_class   <= current_class_next;
        remaining_bytes <= remaining_bytes_next;
        length_high     <= length_high_next;
        scan_follows    <= scan_follows_next;
        scan_saw_ff     <= scan_saw_ff_next;
        seg_total       <= seg_total_next;
        res_valid       <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= r;
    end
  end

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (q_pop && phase == PH_DONE) |=> phase == PH_DONE)
    else $error("parser left done phase");

  a_data_end_is_eoi: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.image_data_end) |->
      (res.seg_class == CL_EOI && res.last_of_segment))
    else $error("image data end without eoi tag");

endmodule
